// ===== rtl/scg_pkg.sv =====
// scg_pkg: shared types, constants and the sine table function of the stepped chirp generator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package scg_pkg;

    localparam int unsigned INC_W    = 32;
    localparam int unsigned RATIO_W  = 18;
    localparam int unsigned AMP_W    = 16;
    localparam int unsigned OFS_W    = 16;
    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned SINE_W   = 16;
    localparam int unsigned SAMPLE_W = 17;
    localparam int unsigned PROD_W   = INC_W + RATIO_W;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [INC_W-1:0]   START_INC_RST   = 32'd34178276;
    localparam logic [RATIO_W-1:0] RATIO_RST       = 18'd43691;
    localparam logic [AMP_W-1:0]   AMP_RST         = 16'd16384;
    localparam logic [OFS_W-1:0]   OFS_RST         = 16'd0;
    localparam logic [COUNT_W-1:0] TOTAL_RST       = 32'd1000001;
    localparam logic [63:0]        HALF_PI_Q30     = 64'd1686629713;
    localparam logic [PROD_W-1:0]  ROUND_HALF      = 50'd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_INC = 3'd0,
        CFG_RATIO     = 3'd1,
        CFG_AMP       = 3'd2,
        CFG_OFFSET    = 3'd3,
        CFG_TOTAL     = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LUT  = 4'b0010,
        S_AMP  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    // truncating unsigned division by shift and subtract, table build only
    function automatic logic [63:0] udiv64(input logic [63:0] num,
                                           input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // quarter-wave sine entry, q1.15, taylor series to x^15 in q2.30
    function automatic logic [SINE_W-1:0] sine_q15(input int unsigned idx,
                                                   input int unsigned bits);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        logic [63:0] dv;
        x = (HALF_PI_Q30 * 64'(idx)) >> bits;
        term = x;
        sum = x;
        for (int unsigned k = 1; k <= 7; k++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            dv = 64'((2 * k) * (2 * k + 1));
            term = udiv64(term, dv);
            if (k % 2 == 1)
            begin
                sum = (sum >= term) ? sum - term : 64'd0;
            end
            else
            begin
                sum = sum + term;
            end
        end
        v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return v[SINE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/stepped_chirp_generator.sv =====
// stepped_chirp_generator: top level, sequencer, sweep state and output register
// depends on scg_pkg, scg_sine_rom and scg_mul
`timescale 1ns / 1ps
`default_nettype none

// Direct digital synthesis stepped chirp. Each input transfer is one sample
// tick; restart=1 clears phase and count and reloads start_increment first.
// A tick steps through accumulate, table read, amplitude multiply and
// output load in turn, as the single shared 32x18 multiplier scales the
// increment after a period wrap and then scales the sine by the amplitude.
// in_stall is high while a tick is being worked and while the output register
// still holds an untaken result at the output step. Once the sweep has given
// total_samples samples, ticks without restart are taken and give nothing.
// The sine table is a constant quarter-wave rom of 2^SINE_TABLE_BITS+1
// entries with registered read. Configuration writes are always taken.
module stepped_chirp_generator #(
    parameter int unsigned SINE_TABLE_BITS = 10
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              restart,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [scg_pkg::SAMPLE_W-1:0]    sample,
    output logic                                   period_wrap,
    output logic                                   last,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [scg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [scg_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import scg_pkg::*;

    localparam int unsigned QW = SINE_TABLE_BITS;
    localparam logic [QW:0] QUARTER_LEN = (QW+1)'(1) << QW;

    state_t state_reg, state_next;

    logic [INC_W-1:0]   start_inc_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic [AMP_W-1:0]   amp_reg;
    logic [OFS_W-1:0]   ofs_reg;
    logic [COUNT_W-1:0] total_reg;

    logic [INC_W-1:0]   phase_reg, phase_next;
    logic [INC_W-1:0]   inc_reg, inc_next;
    logic [COUNT_W-1:0] done_reg, done_next;
    logic               finished_reg, finished_next;
    logic               wrap_reg, wrap_next;
    logic               last_reg, last_next;
    logic               neg_reg, neg_next;

    logic                       out_valid_reg;
    logic [SAMPLE_W-1:0]        sample_reg;
    logic                       wrap_out_reg;
    logic                       last_out_reg;

    logic               in_xfer, out_xfer, out_free;
    logic               fin_eff;
    logic [INC_W-1:0]   phase_eff, inc_eff;
    logic [COUNT_W-1:0] done_eff;
    logic [INC_W:0]     acc_sum;
    logic [COUNT_W:0]   done_inc;
    logic               tick_last;

    logic [OFS_W-1:0]   angle;
    logic [QW-1:0]      p_idx;
    logic [QW:0]        rom_addr;
    logic               rom_en;
    logic [SINE_W-1:0]  rom_data;

    logic               mul_en;
    logic [INC_W-1:0]   mul_a;
    logic [RATIO_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_prod;
    logic [PROD_W-INC_W-1:0] scaled_hi;
    logic [INC_W-1:0]   scaled_sat;
    logic [PROD_W-1:0]  rounded;
    logic [SAMPLE_W-1:0] mag;

    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid_reg && !out_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_inc_reg <= START_INC_RST;
            ratio_reg     <= RATIO_RST;
            amp_reg       <= AMP_RST;
            ofs_reg       <= OFS_RST;
            total_reg     <= TOTAL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_START_INC: start_inc_reg <= cfg_data;
                CFG_RATIO:     ratio_reg     <= cfg_data[RATIO_W-1:0];
                CFG_AMP:       amp_reg       <= cfg_data[AMP_W-1:0];
                CFG_OFFSET:    ofs_reg       <= cfg_data[OFS_W-1:0];
                CFG_TOTAL:     total_reg     <= cfg_data;
                default:       ;
            endcase
        end
    end

    // restart applied ahead of the tick
    assign fin_eff   = restart ? 1'b0 : finished_reg;
    assign phase_eff = restart ? '0 : phase_reg;
    assign inc_eff   = restart ? start_inc_reg : inc_reg;
    assign done_eff  = restart ? '0 : done_reg;
    assign acc_sum   = {1'b0, phase_eff} + {1'b0, inc_eff};
    assign done_inc  = {1'b0, done_eff} + (COUNT_W+1)'(1);
    assign tick_last = (done_inc >= {1'b0, total_reg});

    // table lookup address
    assign angle    = phase_reg[INC_W-1 -: OFS_W] + ofs_reg;
    assign p_idx    = angle[OFS_W-3 -: QW];
    assign rom_addr = angle[OFS_W-2] ? (QUARTER_LEN - {1'b0, p_idx}) : {1'b0, p_idx};
    assign rom_en   = (state_reg == S_LUT);

    // shared multiplier operands
    assign mul_en = (state_reg == S_LUT) || (state_reg == S_AMP);
    assign mul_a  = (state_reg == S_LUT) ? inc_reg : INC_W'(amp_reg);
    assign mul_b  = (state_reg == S_LUT) ? ratio_reg : RATIO_W'(rom_data);

    assign scaled_hi  = mul_prod[PROD_W-1 -: (PROD_W-INC_W)];
    assign scaled_sat = (|scaled_hi[PROD_W-INC_W-1 -: 2]) ? '1
                                                         : mul_prod[INC_W+15:16];
    assign rounded = mul_prod + ROUND_HALF;
    assign mag     = rounded[SAMPLE_W+14:15];

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        inc_next      = inc_reg;
        done_next     = done_reg;
        finished_next = finished_reg;
        wrap_next     = wrap_reg;
        last_next     = last_reg;
        neg_next      = neg_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    phase_next    = phase_eff;
                    inc_next      = inc_eff;
                    done_next     = done_eff;
                    finished_next = fin_eff;
                    if (!fin_eff)
                    begin
                        wrap_next  = acc_sum[INC_W];
                        phase_next = acc_sum[INC_W] ? '0 : acc_sum[INC_W-1:0];
                        last_next  = tick_last;
                        if (tick_last)
                        begin
                            finished_next = 1'b1;
                        end
                        else
                        begin
                            done_next = done_inc[COUNT_W-1:0];
                        end
                        state_next = S_LUT;
                    end
                end
            end
            S_LUT:
            begin
                neg_next   = angle[OFS_W-1];
                state_next = S_AMP;
            end
            S_AMP:
            begin
                if (wrap_reg)
                begin
                    inc_next = scaled_sat;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            phase_reg    <= '0;
            inc_reg      <= START_INC_RST;
            done_reg     <= '0;
            finished_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            inc_reg      <= inc_next;
            done_reg     <= done_next;
            finished_reg <= finished_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wrap_reg <= wrap_next;
        last_reg <= last_next;
        neg_reg  <= neg_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_OUT && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_xfer)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && out_free)
        begin
            sample_reg   <= neg_reg ? (SAMPLE_W'(0) - mag) : mag;
            wrap_out_reg <= wrap_reg;
            last_out_reg <= last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign sample      = sample_reg;
    assign period_wrap = wrap_out_reg;
    assign last        = last_out_reg;

    scg_sine_rom #(
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_rom (
        .clk  (clk),
        .en   (rom_en),
        .addr (rom_addr),
        .data (rom_data)
    );

    scg_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

endmodule

`default_nettype wire

// ===== rtl/scg_sine_rom.sv =====
// scg_sine_rom: constant quarter-wave sine table with registered read
// depends on scg_pkg for the table function
`timescale 1ns / 1ps
`default_nettype none

module scg_sine_rom #(
    parameter int unsigned SINE_TABLE_BITS = 10
) (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic [SINE_TABLE_BITS:0]          addr,
    output logic      [scg_pkg::SINE_W-1:0]        data
);
    import scg_pkg::*;

    localparam int unsigned DEPTH = (1 << SINE_TABLE_BITS) + 1;

    logic [SINE_W-1:0] table_vals [0:DEPTH-1];
    logic [SINE_W-1:0] data_reg;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_entry
        localparam logic [SINE_W-1:0] VAL = sine_q15(i, SINE_TABLE_BITS);
        assign table_vals[i] = VAL;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= table_vals[addr];
        end
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ===== rtl/scg_mul.sv =====
// scg_mul: shared unsigned multiplier with registered product
// depends on scg_pkg for operand widths
`timescale 1ns / 1ps
`default_nettype none

module scg_mul (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [scg_pkg::INC_W-1:0]     a,
    input  wire logic [scg_pkg::RATIO_W-1:0]   b,
    output logic      [scg_pkg::PROD_W-1:0]    prod
);
    import scg_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PROD_W'(a) * PROD_W'(b);
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire
